[src/audio_capture_packet_deframer_macros.svh]
// Assertion helpers shared by the deframer modules.
`ifndef AUDIO_CAPTURE_PACKET_DEFRAMER_MACROS_SVH
`define AUDIO_CAPTURE_PACKET_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACPD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ACPD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[src/acpd_pkg.sv]
package acpd_pkg;

  localparam int HEADER_BYTES = 48;
  localparam int MAX_SAMPLES  = 4096;
  localparam int SAMPLE_W     = 13;
  localparam int POS_W        = 14;
  localparam logic [POS_W-1:0] POS_LIMIT = 14'd16383;

  localparam logic [31:0] MAGIC_WORD      = 32'h4155_4443;
  localparam logic [31:0] CAPTURE_MESSAGE = 32'd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAGMASK = 3'd4;

  localparam logic [15:0]         RST_VERSION  = 16'd1;
  localparam logic [31:0]         RST_RATE     = 32'd48000;
  localparam logic [31:0]         RST_CHANNELS = 32'd1;
  localparam logic [SAMPLE_W-1:0] RST_SAMPLES  = 13'd480;
  localparam logic [31:0]         RST_FLAGMASK = 32'd7;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LENGTH  = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_TYPE    = 3'd4;
  localparam logic [2:0] ST_SIZE    = 3'd5;
  localparam logic [2:0] ST_FORMAT  = 3'd6;
  localparam logic [2:0] ST_FLAGS   = 3'd7;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         item_kind;
    logic [63:0]        sequence_number;
    logic signed [63:0] capture_time;
    logic [31:0]        frame_flags;
    logic signed [15:0] pcm_sample;
    logic [11:0]        sample_index;
    logic [2:0]         status;
  } result_t;

  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } push_t;

endpackage

[src/acpd_ifs.sv]
interface acpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface acpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [63:0]        sequence_number;
  logic signed [63:0] capture_time;
  logic [31:0]        frame_flags;
  logic signed [15:0] pcm_sample;
  logic [11:0]        sample_index;
  logic [2:0]         status;

  modport source (output valid, output item_kind, output sequence_number,
                  output capture_time, output frame_flags, output pcm_sample,
                  output sample_index, output status, input ready);
  modport sink (input valid, input item_kind, input sequence_number,
                input capture_time, input frame_flags, input pcm_sample,
                input sample_index, input status, output ready);
endinterface

[src/acpd_core.sv]
`include "audio_capture_packet_deframer_macros.svh"

module acpd_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             take,
  input  logic [7:0]                       byte_in,
  input  logic                             last_in,
  output logic                             busy,
  output acpd_pkg::push_t                  push
);

  localparam int PW = acpd_pkg::POS_W;
  localparam logic [PW-1:0] POS_MAGIC_END    = PW'(3);
  localparam logic [PW-1:0] POS_VERSION_END  = PW'(5);
  localparam logic [PW-1:0] POS_TYPE_END     = PW'(7);
  localparam logic [PW-1:0] POS_SIZE_END     = PW'(11);
  localparam logic [PW-1:0] POS_FLAGS_END    = PW'(15);
  localparam logic [PW-1:0] POS_SEQ_END      = PW'(23);
  localparam logic [PW-1:0] POS_TIME_END     = PW'(31);
  localparam logic [PW-1:0] POS_RATE_END     = PW'(35);
  localparam logic [PW-1:0] POS_CHANNELS_END = PW'(39);
  localparam logic [PW-1:0] POS_COUNT_END    = PW'(43);
  localparam logic [PW-1:0] POS_HEADER_END   = PW'(acpd_pkg::HEADER_BYTES - 1);
  localparam logic [PW-1:0] POS_BODY         = PW'(acpd_pkg::HEADER_BYTES);

  function automatic logic [2:0] field_lane(input logic [5:0] p);
    logic [5:0] start;
    if (p < 6'd4) start = 6'd0;
    else if (p < 6'd6) start = 6'd4;
    else if (p < 6'd8) start = 6'd6;
    else if (p < 6'd12) start = 6'd8;
    else if (p < 6'd16) start = 6'd12;
    else if (p < 6'd24) start = 6'd16;
    else if (p < 6'd32) start = 6'd24;
    else if (p < 6'd36) start = 6'd32;
    else if (p < 6'd40) start = 6'd36;
    else if (p < 6'd44) start = 6'd40;
    else start = 6'd44;
    return 3'(p - start);
  endfunction

  logic                                stg_valid_r;
  logic [7:0]                          stg_byte_r;
  logic                                stg_last_r;

  logic [15:0]                         exp_version_r;
  logic [31:0]                         exp_rate_r;
  logic [31:0]                         exp_channels_r;
  logic [acpd_pkg::SAMPLE_W-1:0]       frame_samples_r;
  logic [31:0]                         flag_mask_r;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [63:0]   shift_r, shift_nxt;
  logic [63:0]   seq_r, seq_nxt;
  logic [63:0]   time_r, time_nxt;
  logic [31:0]   flags_r, flags_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [7:0]    low_r, low_nxt;

  logic [acpd_pkg::SAMPLE_W-1:0] total;
  logic [PW-1:0]                 len;
  logic [PW-1:0]                 seen;
  logic [PW-1:0]                 off;
  logic [2:0]                    lane;
  logic [63:0]                   shift_v;
  logic [31:0]                   w;
  logic [2:0]                    code;
  logic                          in_header;
  logic                          in_body;
  logic                          finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= take;
    end
    if (take) begin
      stg_byte_r <= byte_in;
      stg_last_r <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r   <= acpd_pkg::RST_VERSION;
      exp_rate_r      <= acpd_pkg::RST_RATE;
      exp_channels_r  <= acpd_pkg::RST_CHANNELS;
      frame_samples_r <= acpd_pkg::RST_SAMPLES;
      flag_mask_r     <= acpd_pkg::RST_FLAGMASK;
    end else if (cfg_we) begin
      case (cfg_index)
        acpd_pkg::CFG_VERSION:  exp_version_r   <= cfg_wdata[15:0];
        acpd_pkg::CFG_RATE:     exp_rate_r      <= cfg_wdata;
        acpd_pkg::CFG_CHANNELS: exp_channels_r  <= cfg_wdata;
        acpd_pkg::CFG_SAMPLES:  frame_samples_r <= cfg_wdata[acpd_pkg::SAMPLE_W-1:0];
        acpd_pkg::CFG_FLAGMASK: flag_mask_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    total = (frame_samples_r > acpd_pkg::SAMPLE_W'(acpd_pkg::MAX_SAMPLES))
          ? acpd_pkg::SAMPLE_W'(acpd_pkg::MAX_SAMPLES) : frame_samples_r;
    len   = POS_BODY + PW'({total, 1'b0});
    seen  = (pos_r < acpd_pkg::POS_LIMIT) ? pos_r + PW'(1) : acpd_pkg::POS_LIMIT;
    off   = pos_r - POS_BODY;
    in_header = pos_r < POS_BODY;
    in_body   = !in_header && (pos_r < len);
    lane    = field_lane(pos_r[5:0]);
    shift_v = shift_r | (64'(stg_byte_r) << {lane, 3'b000});
    w       = shift_v[31:0];

    code   = acpd_pkg::ST_OK;
    finish = 1'b0;
    if (in_header) begin
      case (pos_r)
        POS_MAGIC_END: begin
          finish = 1'b1;
          if (w != acpd_pkg::MAGIC_WORD) code = acpd_pkg::ST_MAGIC;
        end
        POS_VERSION_END: begin
          finish = 1'b1;
          if (w != {16'd0, exp_version_r}) code = acpd_pkg::ST_VERSION;
        end
        POS_TYPE_END: begin
          finish = 1'b1;
          if (w != acpd_pkg::CAPTURE_MESSAGE) code = acpd_pkg::ST_TYPE;
        end
        POS_SIZE_END: begin
          finish = 1'b1;
          if (w != 32'(len)) code = acpd_pkg::ST_SIZE;
        end
        POS_FLAGS_END: begin
          finish = 1'b1;
          if ((w & ~flag_mask_r) != 32'd0) code = acpd_pkg::ST_FLAGS;
        end
        POS_SEQ_END, POS_TIME_END, POS_HEADER_END: begin
          finish = 1'b1;
        end
        POS_RATE_END: begin
          finish = 1'b1;
          if (w != exp_rate_r) code = acpd_pkg::ST_FORMAT;
        end
        POS_CHANNELS_END: begin
          finish = 1'b1;
          if (w != exp_channels_r) code = acpd_pkg::ST_FORMAT;
        end
        POS_COUNT_END: begin
          finish = 1'b1;
          if (w != 32'(total)) code = acpd_pkg::ST_FORMAT;
        end
        default: ;
      endcase
    end

    err_nxt = err_r;
    if (code != acpd_pkg::ST_OK && (err_r == acpd_pkg::ST_OK || code < err_r)) begin
      err_nxt = code;
    end

    shift_nxt = shift_r;
    seq_nxt   = seq_r;
    time_nxt  = time_r;
    flags_nxt = flags_r;
    low_nxt   = low_r;
    if (in_header) begin
      shift_nxt = finish ? 64'd0 : shift_v;
      if (pos_r == POS_FLAGS_END) flags_nxt = w;
      if (pos_r == POS_SEQ_END) seq_nxt = shift_v;
      if (pos_r == POS_TIME_END) time_nxt = shift_v;
    end else if (in_body && !off[0]) begin
      low_nxt = stg_byte_r;
    end
    pos_nxt = seen;

    push = '0;
    if (stg_valid_r) begin
      if (pos_r == POS_HEADER_END) begin
        push.a_valid           = 1'b1;
        push.a.item_kind       = acpd_pkg::KIND_HEADER;
        push.a.sequence_number = seq_r;
        push.a.capture_time    = time_r;
        push.a.frame_flags     = flags_r;
      end else if (in_body && off[0]) begin
        push.a_valid        = 1'b1;
        push.a.item_kind    = acpd_pkg::KIND_SAMPLE;
        push.a.pcm_sample   = {stg_byte_r, low_r};
        push.a.sample_index = off[12:1];
      end
      if (stg_last_r) begin
        push.b_valid     = 1'b1;
        push.b.item_kind = acpd_pkg::KIND_STATUS;
        push.b.status    = (seen != len) ? acpd_pkg::ST_LENGTH : err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (stg_valid_r && stg_last_r)) begin
      pos_r   <= '0;
      shift_r <= '0;
      seq_r   <= '0;
      time_r  <= '0;
      flags_r <= '0;
      err_r   <= acpd_pkg::ST_OK;
      low_r   <= '0;
    end else if (stg_valid_r) begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      seq_r   <= seq_nxt;
      time_r  <= time_nxt;
      flags_r <= flags_nxt;
      err_r   <= err_nxt;
      low_r   <= low_nxt;
    end
  end

  assign busy = stg_valid_r;

  `ACPD_ASSERT_NXT(a_packet_restart, clk, rst_n, stg_valid_r && stg_last_r, pos_r == '0 && err_r == acpd_pkg::ST_OK)
  `ACPD_ASSERT_IMP(a_sample_in_body, clk, rst_n, push.a_valid && push.a.item_kind == acpd_pkg::KIND_SAMPLE, pos_r >= POS_BODY && pos_r < len)

endmodule

[src/acpd_result_fifo.sv]
`include "audio_capture_packet_deframer_macros.svh"

module acpd_result_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acpd_pkg::push_t               push,
  input  logic                          out_ready,
  output logic                          out_valid,
  output acpd_pkg::result_t             head,
  output logic [acpd_pkg::CNT_W-1:0]    count
);

  localparam int PTR_W = acpd_pkg::PTR_W;
  localparam int CNT_W = acpd_pkg::CNT_W;

  acpd_pkg::result_t mem_r [acpd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  idx_b;
  logic [CNT_W-1:0]  push_cnt;
  logic              pop;

  always_comb begin
    idx_b     = wr_ptr_r + PTR_W'(push.a_valid);
    push_cnt  = CNT_W'(push.a_valid) + CNT_W'(push.b_valid);
    pop       = (count_r != '0) && out_ready;
    count_nxt = count_r + push_cnt - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) mem_r[wr_ptr_r] <= push.a;
    if (push.b_valid) mem_r[idx_b] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  assign out_valid = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

  `ACPD_ASSERT_IMP(a_no_overflow, clk, rst_n, push_cnt != '0, (CNT_W+1)'(count_r) + (CNT_W+1)'(push_cnt) <= (CNT_W+1)'(acpd_pkg::FIFO_DEPTH))
  `ACPD_ASSERT_NXT(a_idle_holds, clk, rst_n, push_cnt == '0 && !pop, $stable(count_r) && $stable(rd_ptr_r))

endmodule

[src/audio_capture_packet_deframer.sv]
// A result passes through the input staging register and then the result queue before it is offered.
// Throughput: one byte per cycle while the queue has room; the end status is a second result of the last byte.
// The output channel moves one result per cycle while its ready is high, through an eight-entry result queue.
// Input stalls while the queue could not take two results from each pending byte.
// Synchronous active-low reset clears packet state and the queue and loads register defaults.
module audio_capture_packet_deframer (
  input  logic                            clk,
  input  logic                            rst_n,
  acpd_in_if.sink                         in_chan,
  acpd_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = acpd_pkg::CNT_W;

  acpd_pkg::push_t   push;
  acpd_pkg::result_t head;
  logic              busy;
  logic              take;
  logic [CNT_W-1:0]  count;
  logic [CNT_W:0]    committed;

  assign committed     = (CNT_W+1)'(count) + (busy ? (CNT_W+1)'(2) : '0);
  assign in_chan.ready = committed <= (CNT_W+1)'(acpd_pkg::FIFO_DEPTH - 2);
  assign take          = in_chan.valid && in_chan.ready;

  acpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .byte_in   (in_chan.data_byte),
    .last_in   (in_chan.end_of_packet),
    .busy      (busy),
    .push      (push)
  );

  acpd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .head      (head),
    .count     (count)
  );

  assign out_chan.item_kind       = head.item_kind;
  assign out_chan.sequence_number = head.sequence_number;
  assign out_chan.capture_time    = head.capture_time;
  assign out_chan.frame_flags     = head.frame_flags;
  assign out_chan.pcm_sample      = head.pcm_sample;
  assign out_chan.sample_index    = head.sample_index;
  assign out_chan.status          = head.status;

endmodule

[tb/sv/tb.sv]
module tb;
  import acpd_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 100;
  localparam int PHASE_BYTES    = 34;
  localparam int REPORT_LIMIT   = 10;
  localparam int CUT_BYTES      = HEADER_BYTES + 16;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned MAGIC_LAST   = 3;
  localparam int unsigned VERSION_LAST = 5;
  localparam int unsigned TYPE_LAST    = 7;
  localparam int unsigned SIZE_LAST    = 11;
  localparam int unsigned FLAGS_LAST   = 15;
  localparam int unsigned SEQ_LAST     = 23;
  localparam int unsigned TIME_LAST    = 31;
  localparam int unsigned RATE_LAST    = 35;
  localparam int unsigned CHAN_LAST    = 39;
  localparam int unsigned COUNT_LAST   = 43;

  typedef enum int {
    FL_MAGIC, FL_VERSION, FL_TYPE, FL_SIZE, FL_FLAGS, FL_RATE, FL_CHANNELS,
    FL_COUNT, FL_SHORT, FL_LONG, FL_N
  } flaw_e;
  localparam int FLAW_W = FL_N;

  typedef struct {
    logic [7:0] data;
    logic       eop;
    bit         wait_drain;
  } byte_item_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  acpd_in_if  in_bus ();
  acpd_out_if out_bus ();

  audio_capture_packet_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies used by the predictor.
  logic [15:0]         m_version;
  logic [31:0]         m_rate;
  logic [31:0]         m_channels;
  logic [SAMPLE_W-1:0] m_samples;
  logic [31:0]         m_flag_mask;

  // Packet state of the predictor.
  logic [POS_W-1:0] rx_pos;
  logic [63:0]      field_acc;
  logic [63:0]      held_seq;
  logic [63:0]      held_time;
  logic [31:0]      held_flags;
  logic [2:0]       first_err;
  logic [7:0]       low_byte;

  result_t    pending_results[$];
  byte_item_t byte_queue[$];
  logic [7:0] frame_bytes[$];

  byte_item_t next_byte;
  result_t    got_result;
  result_t    want_result;

  int send_gap, send_calm, recv_gap, recv_calm;
  int quiet_cycles;
  int mismatch_count, results_checked, samples_checked, bad_frames;
  int bytes_sent, queued_bytes, packets_queued, settings_used;
  int unsigned keep_cap;

  function automatic int unsigned frame_sample_total();
    return (m_samples > MAX_SAMPLES) ? MAX_SAMPLES : m_samples;
  endfunction

  function automatic int unsigned packet_bytes();
    return HEADER_BYTES + 2 * frame_sample_total();
  endfunction

  function automatic int unsigned field_base(input int unsigned p);
    if (p < 4) return 0;
    if (p < 6) return 4;
    if (p < 8) return 6;
    if (p < 12) return 8;
    if (p < 16) return 12;
    if (p < 24) return 16;
    if (p < 32) return 24;
    if (p < 36) return 32;
    if (p < 40) return 36;
    if (p < 44) return 40;
    return 44;
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    if (first_err == ST_OK || code < first_err) first_err = code;
  endfunction

  function automatic void clear_packet();
    rx_pos = '0;
    field_acc = '0;
    held_seq = '0;
    held_time = '0;
    held_flags = '0;
    first_err = ST_OK;
    low_byte = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_VERSION:  m_version = val[15:0];
      CFG_RATE:     m_rate = val;
      CFG_CHANNELS: m_channels = val;
      CFG_SAMPLES:  m_samples = val[SAMPLE_W-1:0];
      CFG_FLAGMASK: m_flag_mask = val;
      default: ;
    endcase
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    int unsigned p, len, start, seen, off;
    logic [31:0] w;
    result_t r;
    p = rx_pos;
    len = packet_bytes();
    if (p < HEADER_BYTES) begin
      start = field_base(p);
      field_acc = field_acc | (64'(b) << (8 * (p - start)));
      w = field_acc[31:0];
      if (p == HEADER_BYTES - 1 || field_base(p + 1) != start) begin
        case (p)
          MAGIC_LAST:   if (w != MAGIC_WORD) flag_error(ST_MAGIC);
          VERSION_LAST: if (w != {16'h0, m_version}) flag_error(ST_VERSION);
          TYPE_LAST:    if (w != CAPTURE_MESSAGE) flag_error(ST_TYPE);
          SIZE_LAST:    if (w != len) flag_error(ST_SIZE);
          FLAGS_LAST: begin
            held_flags = w;
            if ((w & ~m_flag_mask) != 0) flag_error(ST_FLAGS);
          end
          SEQ_LAST:     held_seq = field_acc;
          TIME_LAST:    held_time = field_acc;
          RATE_LAST:    if (w != m_rate) flag_error(ST_FORMAT);
          CHAN_LAST:    if (w != m_channels) flag_error(ST_FORMAT);
          COUNT_LAST:   if (w != frame_sample_total()) flag_error(ST_FORMAT);
          default: ;
        endcase
        field_acc = '0;
      end
      if (p == HEADER_BYTES - 1) begin
        r = '0;
        r.item_kind = KIND_HEADER;
        r.sequence_number = held_seq;
        r.capture_time = held_time;
        r.frame_flags = held_flags;
        pending_results.push_back(r);
      end
    end else if (p < len) begin
      off = p - HEADER_BYTES;
      if (off[0] == 1'b0) begin
        low_byte = b;
      end else begin
        r = '0;
        r.item_kind = KIND_SAMPLE;
        r.pcm_sample = {b, low_byte};
        r.sample_index = off[12:1];
        pending_results.push_back(r);
      end
    end
    seen = (p < POS_LIMIT) ? p + 1 : POS_LIMIT;
    rx_pos = seen[POS_W-1:0];
    if (last) begin
      r = '0;
      r.item_kind = KIND_STATUS;
      r.status = (seen != len) ? ST_LENGTH : first_err;
      pending_results.push_back(r);
      clear_packet();
    end
  endtask

  function automatic int pick_gap(inout int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [FLAW_W-1:0] flaw_bit(input flaw_e f);
    return FLAW_W'(1) << f;
  endfunction

  task automatic queue_packet(input logic [FLAW_W-1:0] flaws, input logic [63:0] seq,
                              input logic [63:0] ts, input logic [31:0] flags,
                              input bit drain_first);
    int unsigned total, len, keep, k;
    logic [31:0] magic, size, rate, chans, count, fl;
    logic [15:0] ver, mtype, smp;
    byte_item_t it;
    total = frame_sample_total();
    len = HEADER_BYTES + 2 * total;
    magic = MAGIC_WORD;
    ver = m_version;
    mtype = CAPTURE_MESSAGE[15:0];
    size = len;
    fl = flags;
    rate = m_rate;
    chans = m_channels;
    count = total;
    if (flaws[FL_MAGIC]) magic ^= 32'h1 << $urandom_range(0, 31);
    if (flaws[FL_VERSION]) ver ^= 16'h1 << $urandom_range(0, 15);
    if (flaws[FL_TYPE]) mtype ^= 16'h1 << $urandom_range(0, 15);
    if (flaws[FL_SIZE]) size ^= 32'h1 << $urandom_range(0, 31);
    if (flaws[FL_RATE]) rate ^= 32'h1 << $urandom_range(0, 31);
    if (flaws[FL_CHANNELS]) chans ^= 32'h1 << $urandom_range(0, 31);
    if (flaws[FL_COUNT]) count ^= 32'h1 << $urandom_range(0, 31);
    if (flaws[FL_FLAGS] && m_flag_mask != '1) begin
      do k = $urandom_range(0, 31); while (m_flag_mask[k]);
      fl[k] = 1'b1;
    end
    frame_bytes.delete();
    put_le(magic, 4);
    put_le(ver, 2);
    put_le(mtype, 2);
    put_le(size, 4);
    put_le(fl, 4);
    put_le(seq, 8);
    put_le(ts, 8);
    put_le(rate, 4);
    put_le(chans, 4);
    put_le(count, 4);
    put_le($urandom, 4);
    for (k = 0; k < total; k++) begin
      smp = 16'($urandom);
      if ($urandom_range(0, 5) == 0) smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      put_le(smp, 2);
    end
    if (flaws[FL_LONG]) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
    end
    keep = frame_bytes.size();
    if (flaws[FL_SHORT]) begin
      case ($urandom_range(0, 2))
        0: keep = $urandom_range(1, HEADER_BYTES - 1);
        1: keep = $urandom_range(1, len - 1);
        default: keep = len - 1;
      endcase
    end
    if (keep_cap != 0 && keep > keep_cap) keep = keep_cap;
    for (k = 0; k < keep; k++) begin
      it.data = frame_bytes[k];
      it.eop = (k == keep - 1);
      it.wait_drain = drain_first && (k == 0);
      byte_queue.push_back(it);
    end
    queued_bytes += keep;
    packets_queued++;
  endtask

  task automatic queue_noise(input int unsigned n);
    byte_item_t it;
    for (int unsigned k = 0; k < n; k++) begin
      it.data = 8'($urandom);
      it.eop = (k == n - 1);
      it.wait_drain = 1'b0;
      byte_queue.push_back(it);
    end
    queued_bytes += n;
    packets_queued++;
  endtask

  task automatic queue_random_packet();
    int unsigned r;
    logic [FLAW_W-1:0] flaws;
    r = $urandom_range(0, 99);
    if (r < 55) flaws = '0;
    else if (r < 85) flaws = flaw_bit(flaw_e'($urandom_range(0, FL_N - 1)));
    else flaws = FLAW_W'($urandom);
    if (r >= 93) queue_noise($urandom_range(1, 64));
    else queue_packet(flaws, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom & m_flag_mask, $urandom_range(0, 9) == 0);
  endtask

  task automatic settle();
    while (byte_queue.size() != 0 || in_bus.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
  endtask

  task automatic load_regs(input logic [15:0] ver, input logic [31:0] rate,
                           input logic [31:0] chans, input logic [SAMPLE_W-1:0] samples,
                           input logic [31:0] mask);
    settle();
    write_reg(CFG_VERSION, {16'($urandom), ver});
    write_reg(CFG_RATE, rate);
    write_reg(CFG_CHANNELS, chans);
    write_reg(CFG_SAMPLES, {19'($urandom), samples});
    write_reg(CFG_FLAGMASK, mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        deframe_byte(in_bus.data_byte, in_bus.end_of_packet);
        bytes_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (byte_queue.size() == 0 ||
                     (byte_queue[0].wait_drain && pending_results.size() != 0)) begin
          in_bus.valid <= 1'b0;
        end else begin
          next_byte = byte_queue.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.data_byte <= next_byte.data;
          in_bus.end_of_packet <= next_byte.eop;
          send_gap = pick_gap(send_calm);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_result = {out_bus.item_kind, out_bus.sequence_number, out_bus.capture_time,
                      out_bus.frame_flags, out_bus.pcm_sample, out_bus.sample_index,
                      out_bus.status};
        results_checked++;
        if (got_result.item_kind == KIND_SAMPLE) samples_checked++;
        if (got_result.item_kind == KIND_STATUS && got_result.status != ST_OK) bad_frames++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: kind %0d status %0d",
                     results_checked, got_result.item_kind, got_result.status);
        end else begin
          want_result = pending_results.pop_front();
          if (got_result.item_kind !== want_result.item_kind ||
              got_result.sequence_number !== want_result.sequence_number ||
              got_result.capture_time !== want_result.capture_time ||
              got_result.frame_flags !== want_result.frame_flags ||
              got_result.pcm_sample !== want_result.pcm_sample ||
              got_result.sample_index !== want_result.sample_index ||
              got_result.status !== want_result.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("result %0d expected: kind %0d seq %h time %h flags %h pcm %h idx %0d st %0d",
                       results_checked, want_result.item_kind, want_result.sequence_number,
                       want_result.capture_time, want_result.frame_flags,
                       want_result.pcm_sample, want_result.sample_index, want_result.status);
              $display("result %0d actual:   kind %0d seq %h time %h flags %h pcm %h idx %0d st %0d",
                       results_checked, got_result.item_kind, got_result.sequence_number,
                       got_result.capture_time, got_result.frame_flags,
                       got_result.pcm_sample, got_result.sample_index, got_result.status);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("audio_capture_packet_deframer test failed");
    $finish;
  end

  initial begin
    int ph;
    logic [FLAW_W-1:0] combo;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.end_of_packet = 1'b0;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet_cycles = 0;
    send_calm = 0;
    recv_calm = 0;
    keep_cap = 0;
    m_version = RST_VERSION;
    m_rate = RST_RATE;
    m_channels = RST_CHANNELS;
    m_samples = RST_SAMPLES;
    m_flag_mask = RST_FLAGMASK;
    clear_packet();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // A cut-off frame at the reset sample count, then a header-only frame that
    // must pass under the reset values of the other registers.
    keep_cap = CUT_BYTES;
    queue_packet('0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom & m_flag_mask, 0);
    keep_cap = 0;
    settle();
    write_reg(CFG_SAMPLES, {19'($urandom), 13'd0});
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_packet('0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom & m_flag_mask, 0);

    load_regs(16'($urandom), 32'd44100, 32'd2, 13'd2, 32'hF0F0_0F0F);
    write_reg(CFG_UNUSED, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_packet('0, '1, 64'h8000_0000_0000_0000, m_flag_mask, 0);
    queue_packet('0, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1);
    for (int f = 0; f < FL_N; f++)
      queue_packet(flaw_bit(flaw_e'(f)), {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom & m_flag_mask, 0);
    combo = flaw_bit(FL_VERSION) | flaw_bit(FL_RATE) | flaw_bit(FL_FLAGS);
    queue_packet(combo, {$urandom, $urandom}, {$urandom, $urandom}, '0, 0);
    combo = flaw_bit(FL_SIZE) | flaw_bit(FL_COUNT) | flaw_bit(FL_TYPE);
    queue_packet(combo, {$urandom, $urandom}, {$urandom, $urandom}, '0, 0);
    combo = flaw_bit(FL_SHORT) | flaw_bit(FL_MAGIC);
    queue_packet(combo, {$urandom, $urandom}, {$urandom, $urandom}, '0, 0);
    queue_noise(1);

    queued_bytes = 0;
    ph = 0;
    while (queued_bytes < RANDOM_BYTES) begin
      if (ph == 0) begin
        load_regs('0, '0, '0, 13'd1, '0);
      end else if (ph == 1) begin
        load_regs('1, '1, '1, 13'd0, '1);
      end else begin
        load_regs(16'($urandom),
                  $urandom_range(0, 1) ? 32'd48000 : 32'($urandom),
                  $urandom_range(0, 1) ? 32'($urandom_range(1, 8)) : 32'($urandom),
                  ($urandom_range(0, 4) == 0) ? 13'($urandom_range(9, 40))
                                              : 13'($urandom_range(0, 8)),
                  $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 15)));
      end
      begin
        int phase_start;
        phase_start = queued_bytes;
        while (queued_bytes - phase_start < PHASE_BYTES && queued_bytes < RANDOM_BYTES)
          queue_random_packet();
      end
      ph++;
    end

    // Largest frame setting: the sample count from the register saturates to the maximum count.
    // The frame is cut short after its first samples.
    load_regs(16'($urandom), 32'($urandom), 32'($urandom), 13'h1FFF, 32'($urandom));
    keep_cap = CUT_BYTES;
    queue_packet('0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom & m_flag_mask, 0);
    keep_cap = 0;

    settle();
    $display("covered %0d packets and %0d bytes over %0d register settings",
             packets_queued, bytes_sent, settings_used);
    $display("checked %0d results: %0d samples, %0d frames ending with an error status",
             results_checked, samples_checked, bad_frames);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("audio_capture_packet_deframer test passed");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatch_count,
               pending_results.size());
      $display("audio_capture_packet_deframer test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/acpd_pkg.sv
src/acpd_ifs.sv
src/acpd_core.sv
src/acpd_result_fifo.sv
src/audio_capture_packet_deframer.sv
tb/sv/tb.sv
